/* hdl/ldbp_pkg.sv */
// shared constants and types for the limited diff bit positions block
package ldbp_pkg;

  localparam int KEEP_LIMIT        = 4;
  localparam int DEFAULT_MAX_BYTES = 32;
  localparam int IDX_W             = 5;
  localparam int BIT_W             = 3;
  localparam int POS_W             = IDX_W + BIT_W;
  localparam int CNT_W             = 3;
  localparam int ONES_W            = 4;

  typedef logic [7:0]       byte_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [BIT_W-1:0] bit_sel_t;

  // set bits of one xor byte: population and the first few bit numbers
  typedef struct packed {
    logic [ONES_W-1:0]              ones;
    bit_sel_t [KEEP_LIMIT-1:0]      bit_num;
  } extract_t;

endpackage

/* hdl/ldbp_if.sv */
// valid/ready channel interfaces for byte pairs and results
interface ldbp_in_if;
  import ldbp_pkg::*;
  logic  valid;
  logic  ready;
  byte_t byte_a;
  byte_t byte_b;
  logic  last;
  modport source (output valid, output byte_a, output byte_b, output last, input ready);
  modport sink   (input valid, input byte_a, input byte_b, input last, output ready);
endinterface

interface ldbp_out_if;
  import ldbp_pkg::*;
  logic valid;
  logic ready;
  logic status;
  cnt_t diff_count;
  pos_t pos0;
  pos_t pos1;
  pos_t pos2;
  pos_t pos3;
  modport source (output valid, output status, output diff_count, output pos0, output pos1,
                  output pos2, output pos3, input ready);
  modport sink   (input valid, input status, input diff_count, input pos0, input pos1,
                  input pos2, input pos3, output ready);
endinterface

/* hdl/ldbp_extract.sv */
// set bit count and ascending bit numbers of one xor byte
module ldbp_extract (
  input  ldbp_pkg::byte_t    diff,
  output ldbp_pkg::extract_t ext
);
  import ldbp_pkg::*;

  always_comb begin
    logic [ONES_W-1:0] k;
    k = '0;
    ext.bit_num = '0;
    for (int b = 0; b < 8; b++) begin
      if (diff[b]) begin
        if (k < ONES_W'(KEEP_LIMIT)) begin
          ext.bit_num[k[1:0]] = BIT_W'(b);
        end
        k = k + 1'b1;
      end
    end
    ext.ones = k;
  end

endmodule

/* hdl/limited_diff_bit_positions_core.sv */
// top level: per-string collection of up to four differing bit positions
//
// channel   dir  beat contents
// in_bus    in   byte_a, byte_b, last (one byte pair of the two strings)
// out_bus   out  status, diff_count, pos0..pos3 (one beat per string, on last)
//
// one byte pair per cycle, except while a last pair waits for the result slot; each pair passes the input register,
// and a result appears on out_bus at the same edge at which its last pair leaves that register
// rst_n is synchronous, active low, and clears the string state and both valid flags
// a stalled result holds only pairs marked last; other pairs keep flowing past it
// in_bus.ready falls only when a last pair waits in the input register for the result slot
module limited_diff_bit_positions_core #(
  parameter int MAX_BYTES = ldbp_pkg::DEFAULT_MAX_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  ldbp_in_if.sink     in_bus,
  ldbp_out_if.source  out_bus
);
  import ldbp_pkg::*;

  // input register
  logic  s1_valid_r;
  byte_t s1_a_r;
  byte_t s1_b_r;
  logic  s1_last_r;

  // string state
  idx_t  byte_idx_r, byte_idx_nxt;
  cnt_t  found_r, found_nxt;
  logic  too_many_r, too_many_nxt;
  logic  full_r, full_nxt;
  pos_t  pos_r   [KEEP_LIMIT];
  pos_t  pos_nxt [KEEP_LIMIT];

  // result register
  logic  out_valid_r;
  logic  out_status_r;
  cnt_t  out_count_r;
  pos_t  out_pos_r [KEEP_LIMIT];

  logic     out_free;
  logic     s1_fire;
  logic     in_fire;
  logic     active;
  logic     over;
  logic [ONES_W-1:0] sum;
  extract_t ext;

  assign out_free = !out_valid_r || out_bus.ready;
  // a last pair needs the result slot, others move on regardless
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_bus.ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_a_r    <= in_bus.byte_a;
      s1_b_r    <= in_bus.byte_b;
      s1_last_r <= in_bus.last;
    end
  end

  ldbp_extract u_extract (
    .diff (s1_a_r ^ s1_b_r),
    .ext  (ext)
  );

  // one pair: while the string is active, count its differing bits, then either flag overflow or append them
  always_comb begin
    active       = !too_many_r && !full_r;
    sum          = ONES_W'(found_r) + ext.ones;
    over         = active && (sum > ONES_W'(KEEP_LIMIT));
    too_many_nxt = too_many_r || over;
    found_nxt    = (active && !over) ? CNT_W'(sum) : found_r;
    byte_idx_nxt = byte_idx_r;
    full_nxt     = full_r;
    if (active) begin
      if (byte_idx_r == IDX_W'(MAX_BYTES - 1)) begin
        full_nxt = 1'b1;
      end else begin
        byte_idx_nxt = byte_idx_r + 1'b1;
      end
    end
    for (int i = 0; i < KEEP_LIMIT; i++) begin
      pos_nxt[i] = pos_r[i];
      // slot i takes the (i - found)th set bit of this byte
      if (active && !over && (CNT_W'(i) >= found_r) && (ONES_W'(i) < sum)) begin
        pos_nxt[i] = {byte_idx_r, ext.bit_num[2'(i) - found_r[1:0]]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s1_fire && s1_last_r)) begin
      byte_idx_r <= '0;
      found_r    <= '0;
      too_many_r <= 1'b0;
      full_r     <= 1'b0;
      for (int i = 0; i < KEEP_LIMIT; i++) begin
        pos_r[i] <= '0;
      end
    end else if (s1_fire) begin
      byte_idx_r <= byte_idx_nxt;
      found_r    <= found_nxt;
      too_many_r <= too_many_nxt;
      full_r     <= full_nxt;
      pos_r      <= pos_nxt;
    end
  end

  // result beat, built from the state as it stands after the last pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_status_r <= too_many_nxt;
      out_count_r  <= too_many_nxt ? '0 : found_nxt;
      for (int i = 0; i < KEEP_LIMIT; i++) begin
        out_pos_r[i] <= (!too_many_nxt && (CNT_W'(i) < found_nxt)) ? pos_nxt[i] : '0;
      end
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.status     = out_status_r;
  assign out_bus.diff_count = out_count_r;
  assign out_bus.pos0       = out_pos_r[0];
  assign out_bus.pos1       = out_pos_r[1];
  assign out_bus.pos2       = out_pos_r[2];
  assign out_bus.pos3       = out_pos_r[3];

  // never keep more positions than slots
  a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
    found_r <= CNT_W'(KEEP_LIMIT))
    else $error("kept position count beyond limit");

  // a last pair only leaves the input register when the result slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |-> out_free)
    else $error("result overwritten while pending");

  // string state is clear after the last pair
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (found_r == '0 && !too_many_r && !full_r && byte_idx_r == '0))
    else $error("string state not cleared after last pair");

  // overflow results carry no count
  a_overflow_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_count_r == '0 && out_pos_r[0] == '0))
    else $error("overflow result carries positions");

endmodule
